// ===== src/cafs_pkg.sv =====
// Shared types and constants of the contrast autofocus search block:
// action codes, search phases, register indexes and the result descriptor.
// No dependencies.
package cafs_pkg;

	localparam int CONTRAST_BITS_DEF = 24;
	localparam int POSITION_BITS_DEF = 16;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BACKLASH  = 2'd2;

	localparam logic [15:0] THRESHOLD_RST = 16'd3277;
	localparam logic [7:0]  LIMIT_RST     = 8'd10;
	localparam logic [3:0]  BACKLASH_RST  = 4'd5;

	localparam logic CMD_START   = 1'b0;
	localparam logic CMD_OBSERVE = 1'b1;

	typedef enum logic [1:0] {
		ACT_MEASURE = 2'd0,
		ACT_UP      = 2'd1,
		ACT_DOWN    = 2'd2,
		ACT_DONE    = 2'd3
	} action_t;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_INIT  = 4'b0010,
		PH_OTHER = 4'b0100,
		PH_RETRY = 4'b1000
	} phase_t;

	// Step beats first, then one tail beat.
	typedef struct packed {
		logic [3:0]  steps;
		logic        step_down;
		action_t     tail_act;
		logic        found;
		logic [15:0] pos;
	} desc_t;

endpackage

// ===== src/cafs_beats.sv =====
// Result sequencer: expands one descriptor into its step beats and tail beat.
// Depends on cafs_pkg.
module cafs_beats (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              desc_valid,
	input  cafs_pkg::desc_t   desc,
	output logic              desc_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        action,
	output logic              found,
	output logic signed [15:0] focus_position,
	output logic              last
);

	cafs_pkg::desc_t desc_q;
	logic            valid_q;
	logic [3:0]      cnt_q;
	logic            tail;

	assign tail       = (cnt_q == 4'd0);
	assign desc_ready = !valid_q || (out_ready && tail);
	assign out_valid  = valid_q;
	assign last       = tail;

	always_comb begin
		if (!tail) begin
			action = desc_q.step_down ? cafs_pkg::ACT_DOWN : cafs_pkg::ACT_UP;
		end else begin
			action = desc_q.tail_act;
		end
	end

	assign found          = tail && desc_q.found;
	assign focus_position = tail ? desc_q.pos : 16'sd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= 4'd0;
		end else if (desc_ready) begin
			valid_q <= desc_valid;
			if (desc_valid) begin
				cnt_q <= desc.steps;
			end
		end else if (out_ready) begin
			cnt_q <= cnt_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (desc_ready && desc_valid) begin
			desc_q <= desc;
		end
	end

endmodule

// ===== src/contrast_autofocus_search.sv =====
// Top level of the hill-climb contrast autofocus sequencer.
// Depends on cafs_pkg and cafs_beats.
//
// An input beat is taken into an input stage; when it leaves that stage the
// search state is updated and a descriptor of its results is handed to the
// result sequencer, which sends one result beat per cycle while out_ready is
// high. An item causes one result beat for a start or an ended search that
// restarts or finishes, two for a step and measure, and backlash_steps plus
// one where the search turns around. The input side takes one beat per cycle
// while results drain, until an input-stage beat waits behind the single
// descriptor held in the sequencer. The new-maximum test compares against a
// stored product of the best contrast and the gain factor, recomputed with a
// single multiplier in any cycle the input stage is empty. A configuration
// beat is taken only while the input stage is empty, and an input beat is not
// taken in a cycle in which a configuration beat is offered.
module contrast_autofocus_search #(
	parameter int CONTRAST_BITS = cafs_pkg::CONTRAST_BITS_DEF,
	parameter int POSITION_BITS = cafs_pkg::POSITION_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [cafs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cafs_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               command,
	input  logic                               reverse_wanted,
	input  logic [23:0]                        contrast,
	input  logic signed [15:0]                 position,
	input  logic                               at_lower_limit,
	input  logic                               at_upper_limit,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [1:0]                         action,
	output logic                               found,
	output logic signed [15:0]                 focus_position,
	output logic                               last
);

	localparam int PROD_W = CONTRAST_BITS + 17;
	localparam logic [32:0] CMAX = (33'd1 << CONTRAST_BITS) - 33'd1;

	logic [15:0] thr_q;
	logic [7:0]  limit_q;
	logic [3:0]  backlash_q;

	logic                     s1_valid_q;
	logic                     command_s1;
	logic                     rw_s1;
	logic [CONTRAST_BITS-1:0] contrast_s1;
	logic [POSITION_BITS-1:0] position_s1;
	logic                     lower_s1;
	logic                     upper_s1;

	cafs_pkg::phase_t         phase_q, phase_n;
	logic                     wrev_q, wrev_n;
	logic                     started_q, started_n;
	logic                     srev_q, srev_n;
	logic                     first_q, first_n;
	logic                     rose_q, rose_n;
	logic [7:0]               miss_q, miss_n;
	logic [CONTRAST_BITS-1:0] best_q, best_n;
	logic [POSITION_BITS-1:0] bpos_q, bpos_n;
	logic [PROD_W-1:0]        scaled_q;

	logic [CONTRAST_BITS-1:0] c_sat;
	logic [CONTRAST_BITS-1:0] mult_op;
	logic [16:0]              gain;
	logic [PROD_W-1:0]        prod;
	logic                     gt;
	logic                     take, clr, stop, fin, fin_found, bl, nb, nb_dir;
	logic [POSITION_BITS-1:0] bpos_cur;
	logic                     desc_make, desc_ready, s1_go, in_acc;
	cafs_pkg::desc_t          desc;

	assign cfg_ready = !s1_valid_q;
	assign desc_make = !command_s1 || (phase_q != cafs_pkg::PH_IDLE);
	assign s1_go     = s1_valid_q && (!desc_make || desc_ready);
	assign in_ready  = (!s1_valid_q || s1_go) && !cfg_valid;
	assign in_acc    = in_valid && in_ready;

	assign c_sat = ({9'd0, contrast} > CMAX) ? CMAX[CONTRAST_BITS-1:0]
		: CONTRAST_BITS'(contrast);

	assign gain    = {1'b1, 16'd0} + {1'b0, thr_q};
	assign mult_op = s1_valid_q ? contrast_s1 : best_q;
	assign prod    = PROD_W'(mult_op) * PROD_W'(gain);
	assign gt      = {1'b0, contrast_s1, 16'd0} > scaled_q;

	always_comb begin
		phase_n   = phase_q;
		wrev_n    = wrev_q;
		started_n = started_q;
		srev_n    = srev_q;
		first_n   = first_q;
		rose_n    = rose_q;
		miss_n    = miss_q;
		take      = 1'b0;
		clr       = 1'b0;
		stop      = 1'b0;
		fin       = 1'b0;
		fin_found = 1'b0;
		bl        = 1'b0;
		nb        = 1'b0;
		nb_dir    = 1'b0;
		bpos_cur  = bpos_q;
		desc      = '{steps: 4'd0, step_down: 1'b0, tail_act: cafs_pkg::ACT_MEASURE,
			found: 1'b0, pos: 16'd0};
		if (!command_s1) begin
			wrev_n    = rw_s1;
			started_n = (rw_s1 && lower_s1) || (!rw_s1 && upper_s1);
			phase_n   = cafs_pkg::PH_INIT;
			nb        = 1'b1;
			nb_dir    = started_n ? !rw_s1 : rw_s1;
		end else if (phase_q != cafs_pkg::PH_IDLE) begin
			if (first_q) begin
				first_n = 1'b0;
				take    = 1'b1;
			end else begin
				if (gt) begin
					take   = 1'b1;
					rose_n = 1'b1;
					miss_n = 8'd0;
				end else if (miss_q != 8'hFF) begin
					miss_n = miss_q + 8'd1;
				end
				stop = (miss_n >= limit_q);
			end
			if (srev_q ? lower_s1 : upper_s1) begin
				stop = 1'b1;
			end
			if (take) begin
				bpos_cur = position_s1;
			end
			if (!stop) begin
				desc.steps     = 4'd1;
				desc.step_down = srev_q;
			end else begin
				unique case (phase_q)
					cafs_pkg::PH_INIT: begin
						if (rose_n && !started_q) begin
							fin       = 1'b1;
							fin_found = 1'b1;
						end else if (rose_n) begin
							bl      = 1'b1;
							phase_n = cafs_pkg::PH_RETRY;
							nb      = 1'b1;
							nb_dir  = wrev_q;
						end else begin
							phase_n = cafs_pkg::PH_OTHER;
							nb      = 1'b1;
							nb_dir  = !srev_q;
						end
					end
					cafs_pkg::PH_RETRY: begin
						if (rose_n) begin
							fin       = 1'b1;
							fin_found = 1'b1;
						end else if (started_q) begin
							phase_n = cafs_pkg::PH_OTHER;
							nb      = 1'b1;
							nb_dir  = wrev_q;
						end else begin
							fin = 1'b1;
						end
					end
					cafs_pkg::PH_OTHER: begin
						if (rose_n && started_q) begin
							fin       = 1'b1;
							fin_found = 1'b1;
						end else if (rose_n) begin
							bl      = 1'b1;
							phase_n = cafs_pkg::PH_RETRY;
							nb      = 1'b1;
							nb_dir  = wrev_q;
						end else begin
							fin = 1'b1;
						end
					end
					default: begin
						phase_n = cafs_pkg::PH_IDLE;
					end
				endcase
			end
		end
		if (fin) begin
			phase_n       = cafs_pkg::PH_IDLE;
			desc.tail_act = cafs_pkg::ACT_DONE;
			desc.found    = fin_found;
			desc.pos      = fin_found ? 16'(bpos_cur) : 16'd0;
		end
		if (bl) begin
			desc.steps     = backlash_q;
			desc.step_down = srev_q;
		end
		if (nb) begin
			srev_n  = nb_dir;
			first_n = 1'b1;
			rose_n  = 1'b0;
			miss_n  = 8'd0;
			clr     = 1'b1;
		end
		best_n = clr ? '0 : (take ? contrast_s1 : best_q);
		bpos_n = clr ? '0 : bpos_cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q      <= cafs_pkg::THRESHOLD_RST;
			limit_q    <= cafs_pkg::LIMIT_RST;
			backlash_q <= cafs_pkg::BACKLASH_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cafs_pkg::REG_THRESHOLD: thr_q      <= cfg_data;
				cafs_pkg::REG_LIMIT:     limit_q    <= cfg_data[7:0];
				cafs_pkg::REG_BACKLASH:  backlash_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_go) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			command_s1  <= command;
			rw_s1       <= reverse_wanted;
			contrast_s1 <= c_sat;
			position_s1 <= POSITION_BITS'(position);
			lower_s1    <= at_lower_limit;
			upper_s1    <= at_upper_limit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= cafs_pkg::PH_IDLE;
			wrev_q    <= 1'b0;
			started_q <= 1'b0;
			srev_q    <= 1'b0;
			first_q   <= 1'b0;
			rose_q    <= 1'b0;
			miss_q    <= 8'd0;
			best_q    <= '0;
			bpos_q    <= '0;
			scaled_q  <= '0;
		end else if (s1_go) begin
			phase_q   <= phase_n;
			wrev_q    <= wrev_n;
			started_q <= started_n;
			srev_q    <= srev_n;
			first_q   <= first_n;
			rose_q    <= rose_n;
			miss_q    <= miss_n;
			best_q    <= best_n;
			bpos_q    <= bpos_n;
			if (clr) begin
				scaled_q <= '0;
			end else if (take) begin
				scaled_q <= prod;
			end
		end else if (!s1_valid_q) begin
			scaled_q <= prod;
		end
	end

	cafs_beats u_beats (
		.clk            (clk),
		.arst_n         (arst_n),
		.desc_valid     (s1_valid_q && desc_make),
		.desc           (desc),
		.desc_ready     (desc_ready),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.action         (action),
		.found          (found),
		.focus_position (focus_position),
		.last           (last)
	);

endmodule

// ===== src/cafs_checker.sv =====
// Port-level checks of the autofocus search block, bound to its top level.
// Depends on cafs_pkg and contrast_autofocus_search.
module cafs_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [1:0]        action,
	input logic              found,
	input logic signed [15:0] focus_position,
	input logic              last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(action) && $stable(last)
			&& $stable(found) && $stable(focus_position))
		else $error("result beat changed while stalled");

	a_found_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> action == cafs_pkg::ACT_DONE)
		else $error("found outside a finished beat");

	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> focus_position == 16'sd0)
		else $error("focus position without a found point");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == cafs_pkg::ACT_DONE |-> last)
		else $error("finished beat not marked last");

	a_step_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action == cafs_pkg::ACT_UP || action == cafs_pkg::ACT_DOWN) |-> !last)
		else $error("step beat marked last");

endmodule

bind contrast_autofocus_search cafs_checker u_cafs_checker (.*);
